@@ rtl/wtsr_pkg.sv @@
// Shared constants, types and a helper function of the temperature statistics responder.
package wtsr_pkg;

  // Depth of the sample window.
  localparam int WINDOW = 100;

  localparam int SAMPLE_W  = 16;
  localparam int SLOT_W    = $clog2(WINDOW);
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Request kinds carried in req_type.
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_FRAME  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  // Request opcodes.
  localparam logic [7:0] OP_LATEST = 8'd11;
  localparam logic [7:0] OP_MAX    = 8'd21;
  localparam logic [7:0] OP_MIN    = 8'd31;
  localparam logic [7:0] OP_MEAN   = 8'd41;
  localparam logic [7:0] OP_ALL    = 8'd51;

  // Response codes and frame marks.
  localparam logic [7:0] RSP_LATEST = 8'd12;
  localparam logic [7:0] RSP_MAX    = 8'd22;
  localparam logic [7:0] RSP_MIN    = 8'd32;
  localparam logic [7:0] RSP_MEAN   = 8'd42;
  localparam logic [7:0] RSP_ALL    = 8'd52;
  localparam logic [7:0] START_MARK = 8'd60;
  localparam logic [7:0] END_MARK   = 8'd62;

  localparam logic [3:0] LEN_SINGLE = 4'd5;
  localparam logic [3:0] LEN_ALL    = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_sample;
    logic request;
    logic read;
    logic scan;
    logic div_load;
    logic div_step;
    logic div_finish;
  } wtsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic div_done;
  } wtsr_status_t;

  // Whole degrees truncated toward zero, low 8 bits kept.
  function automatic logic [7:0] to_degrees(input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] adj;
    adj = v + (v[SAMPLE_W-1] ? 16'sd15 : 16'sd0);
    return adj[11:4];
  endfunction

endpackage

@@ rtl/wtsr_req_if.sv @@
// Request channel: valid/ready handshake with the request word.
interface wtsr_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic signed [15:0]  sample_value;
  logic [7:0]          first_byte;
  logic [7:0]          op_byte;

  modport source(output valid, req_type, sample_value, first_byte, op_byte, input ready);
  modport sink(input valid, req_type, sample_value, first_byte, op_byte, output ready);
endinterface

@@ rtl/wtsr_rsp_if.sv @@
// Response channel: valid/ready handshake with the returned frame byte.
interface wtsr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] byte_position;

  modport source(output valid, out_byte, byte_position, input ready);
  modport sink(input valid, out_byte, byte_position, output ready);
endinterface

@@ rtl/wtsr_ctrl.sv @@
// Controller state machine: sequences sample scan and division, manages handshakes.
module wtsr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic [1:0]            req_type,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output wtsr_pkg::wtsr_cmd_t   cmd,
  input  wtsr_pkg::wtsr_status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_SCAN     = 4'b0010,
    ST_DIV_LOAD = 4'b0100,
    ST_DIV      = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  // A new word is taken only while idle and with the response slot free or draining.
  assign req_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            wtsr_pkg::REQ_SAMPLE: begin
              cmd.take_sample = 1'b1;
              state_next      = ST_SCAN;
            end
            wtsr_pkg::REQ_FRAME: cmd.request = 1'b1;
            wtsr_pkg::REQ_READ:  cmd.read    = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.div_finish = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.read) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/wtsr_datapath.sv @@
// Datapath: sample window memory, statistics scan, divider, response frame and read port.
module wtsr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  wtsr_pkg::wtsr_cmd_t               cmd,
  output wtsr_pkg::wtsr_status_t            status,
  input  logic signed [wtsr_pkg::SAMPLE_W-1:0] sample_value,
  input  logic [7:0]                        first_byte,
  input  logic [7:0]                        op_byte,
  output logic [7:0]                        out_byte,
  output logic [2:0]                        byte_position
);

  localparam int SAMPLE_W  = wtsr_pkg::SAMPLE_W;
  localparam int SLOT_W    = wtsr_pkg::SLOT_W;
  localparam int CNT_W     = wtsr_pkg::CNT_W;
  localparam int SUM_W     = wtsr_pkg::SUM_W;
  localparam int DIV_CNT_W = wtsr_pkg::DIV_CNT_W;

  // Sample window. Slots at or above the fill count were never written and read as zero.
  logic signed [SAMPLE_W-1:0] mem [wtsr_pkg::WINDOW];
  logic signed [SAMPLE_W-1:0] rd_data;

  logic [SLOT_W-1:0]          write_slot;
  logic [CNT_W-1:0]           sample_count;
  logic signed [SAMPLE_W-1:0] latest_value, max_value, min_value, mean_value;

  // Scan state.
  logic [CNT_W-1:0]           issue_idx;
  logic                       rd_valid, rd_first, rd_live;
  logic signed [SUM_W-1:0]    sum_acc;
  logic signed [SAMPLE_W-1:0] max_acc, min_acc;
  logic signed [SAMPLE_W-1:0] scan_val;

  // Divider state.
  logic [SUM_W-1:0]           dvd;
  logic [CNT_W:0]             rem;
  logic [DIV_CNT_W-1:0]       div_left;
  logic                       div_neg;
  logic [CNT_W:0]             rem_sh;
  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W-1:0]           quo_signed;

  // Response frame.
  logic [7:0]                 frame [8];
  logic [3:0]                 frame_length;
  logic [2:0]                 read_position;
  logic [7:0]                 rsp_code, rsp_val;
  logic                       op_single;

  logic                       mem_we;
  logic [SLOT_W-1:0]          mem_raddr;

  assign mem_we    = cmd.take_sample;
  assign mem_raddr = issue_idx[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_slot] <= sample_value;
    end
    rd_data <= mem[mem_raddr];
  end

  assign scan_val  = rd_live ? rd_data : '0;
  assign status.scan_done = (issue_idx == CNT_W'(wtsr_pkg::WINDOW)) && !rd_valid;
  assign status.div_done  = (div_left == '0);

  assign sum_mag    = sum_acc[SUM_W-1] ? SUM_W'(-sum_acc) : SUM_W'(sum_acc);
  assign rem_sh     = {rem[CNT_W-1:0], dvd[SUM_W-1]};
  assign quo_signed = div_neg ? (~dvd + SUM_W'(1)) : dvd;

  always_comb begin
    op_single = 1'b1;
    rsp_code  = wtsr_pkg::RSP_LATEST;
    rsp_val   = wtsr_pkg::to_degrees(latest_value);
    case (op_byte)
      wtsr_pkg::OP_LATEST: ;
      wtsr_pkg::OP_MAX: begin
        rsp_code = wtsr_pkg::RSP_MAX;
        rsp_val  = wtsr_pkg::to_degrees(max_value);
      end
      wtsr_pkg::OP_MIN: begin
        rsp_code = wtsr_pkg::RSP_MIN;
        rsp_val  = wtsr_pkg::to_degrees(min_value);
      end
      wtsr_pkg::OP_MEAN: begin
        rsp_code = wtsr_pkg::RSP_MEAN;
        rsp_val  = wtsr_pkg::to_degrees(mean_value);
      end
      default: op_single = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot    <= '0;
      sample_count  <= '0;
      latest_value  <= '0;
      max_value     <= '0;
      min_value     <= '0;
      mean_value    <= '0;
      frame_length  <= '0;
      read_position <= '0;
      rd_valid      <= 1'b0;
      issue_idx     <= '0;
      div_left      <= '0;
    end else begin
      if (cmd.take_sample) begin
        write_slot <= (write_slot == SLOT_W'(wtsr_pkg::WINDOW - 1)) ? '0
                                                                   : write_slot + SLOT_W'(1);
        if (sample_count != CNT_W'(wtsr_pkg::WINDOW)) begin
          sample_count <= sample_count + CNT_W'(1);
        end
        latest_value <= sample_value;
        issue_idx    <= '0;
        rd_valid     <= 1'b0;
        sum_acc      <= '0;
      end

      if (cmd.scan) begin
        if (issue_idx != CNT_W'(wtsr_pkg::WINDOW)) begin
          rd_valid  <= 1'b1;
          rd_first  <= (issue_idx == '0);
          rd_live   <= (issue_idx < sample_count);
          issue_idx <= issue_idx + CNT_W'(1);
        end else begin
          rd_valid <= 1'b0;
        end
        if (rd_valid) begin
          sum_acc <= sum_acc + SUM_W'(scan_val);
          if (rd_first) begin
            max_acc <= scan_val;
            min_acc <= scan_val;
          end else if (scan_val > 0) begin
            if (scan_val > max_acc) max_acc <= scan_val;
            if (scan_val < min_acc) min_acc <= scan_val;
          end
        end
      end

      if (cmd.div_load) begin
        max_value <= max_acc;
        min_value <= min_acc;
        dvd       <= sum_mag;
        div_neg   <= sum_acc[SUM_W-1];
        rem       <= '0;
        div_left  <= DIV_CNT_W'(SUM_W);
      end

      // Restoring division, one quotient bit per cycle.
      if (cmd.div_step) begin
        if (rem_sh >= {1'b0, sample_count}) begin
          rem <= rem_sh - {1'b0, sample_count};
          dvd <= {dvd[SUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          dvd <= {dvd[SUM_W-2:0], 1'b0};
        end
        div_left <= div_left - DIV_CNT_W'(1);
      end

      if (cmd.div_finish) begin
        mean_value <= (sample_count == '0) ? '0 : quo_signed[SAMPLE_W-1:0];
      end

      if (cmd.request && first_byte == wtsr_pkg::START_MARK) begin
        read_position <= '0;
        if (op_byte == wtsr_pkg::OP_ALL) begin
          frame[0]     <= wtsr_pkg::START_MARK;
          frame[1]     <= wtsr_pkg::RSP_ALL;
          frame[2]     <= 8'(wtsr_pkg::LEN_ALL);
          frame[3]     <= wtsr_pkg::to_degrees(latest_value);
          frame[4]     <= wtsr_pkg::to_degrees(max_value);
          frame[5]     <= wtsr_pkg::to_degrees(min_value);
          frame[6]     <= wtsr_pkg::to_degrees(mean_value);
          frame[7]     <= wtsr_pkg::END_MARK;
          frame_length <= wtsr_pkg::LEN_ALL;
        end else if (op_single) begin
          frame[0]     <= wtsr_pkg::START_MARK;
          frame[1]     <= rsp_code;
          frame[2]     <= 8'(wtsr_pkg::LEN_SINGLE);
          frame[3]     <= rsp_val;
          frame[4]     <= wtsr_pkg::END_MARK;
          frame_length <= wtsr_pkg::LEN_SINGLE;
        end
      end

      if (cmd.read) begin
        if (frame_length == '0) begin
          out_byte      <= '0;
          byte_position <= '0;
        end else begin
          out_byte      <= frame[read_position];
          byte_position <= read_position;
          read_position <= ({1'b0, read_position} + 4'd1 == frame_length) ? '0
                                                                          : read_position + 3'd1;
        end
      end
    end
  end

endmodule

@@ rtl/window_temperature_stats_responder.sv @@
// Top level of the temperature window statistics responder.
// A new sample is written into the window, and the next word is taken only after the
// scan and the division are through: one window slot is read from the sample memory
// per cycle to form the sum, maximum and minimum, and the mean comes from a divider
// that produces one quotient bit per cycle. Frame requests and bus reads are handled
// without leaving the idle state; a read's byte waits in an output register, and
// the next word is taken as soon as that register is free or being emptied.
module window_temperature_stats_responder (
  input  logic        clk,
  input  logic        rst,
  wtsr_req_if.sink    req,
  wtsr_rsp_if.source  rsp
);

  wtsr_pkg::wtsr_cmd_t    cmd;
  wtsr_pkg::wtsr_status_t status;

  wtsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  wtsr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample_value  (req.sample_value),
    .first_byte    (req.first_byte),
    .op_byte       (req.op_byte),
    .out_byte      (rsp.out_byte),
    .byte_position (rsp.byte_position)
  );

endmodule

@@ bench/wtsr_stats_checker.sv @@
`timescale 1ns / 100ps
// Checker for the temperature statistics responder: mirrors the window and frame, checks read words.
module wtsr_stats_checker (
  input  logic clk,
  input  logic rst,
  wtsr_req_if  req,
  wtsr_rsp_if  rsp,
  output int   mismatches,
  output int   pending_reads
);

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] pos;
  } frame_read_t;

  logic signed [15:0] window_q [wtsr_pkg::WINDOW];
  int                 slot_q;
  int                 count_q;
  logic signed [15:0] latest_q;
  logic signed [15:0] max_q;
  logic signed [15:0] min_q;
  logic signed [15:0] mean_q;
  logic [7:0]         frame_q [8];
  int                 frame_len_q;
  int                 rd_pos_q;

  frame_read_t expected_reads [$];

  initial begin
    mismatches    = 0;
    pending_reads = 0;
  end

  function automatic void clear_model();
    for (int i = 0; i < wtsr_pkg::WINDOW; i++) window_q[i] = '0;
    for (int i = 0; i < 8; i++) frame_q[i] = '0;
    slot_q      = 0;
    count_q     = 0;
    latest_q    = '0;
    max_q       = '0;
    min_q       = '0;
    mean_q      = '0;
    frame_len_q = 0;
    rd_pos_q    = 0;
    expected_reads.delete();
  endfunction

  // Whole degrees, truncated toward zero, low byte only.
  function automatic logic [7:0] degrees_byte(input logic signed [15:0] v);
    int d;
    d = int'(v) / 16;
    return d[7:0];
  endfunction

  // Slot 0 seeds max and min; the other slots only count when strictly positive.
  function automatic void refresh_stats();
    int                 sum;
    logic signed [15:0] hi;
    logic signed [15:0] lo;
    sum = 0;
    hi  = window_q[0];
    lo  = window_q[0];
    for (int i = 1; i < wtsr_pkg::WINDOW; i++) begin
      if (window_q[i] > 0 && window_q[i] > hi) hi = window_q[i];
      if (window_q[i] > 0 && window_q[i] < lo) lo = window_q[i];
    end
    for (int i = 0; i < wtsr_pkg::WINDOW; i++) sum += int'(window_q[i]);
    max_q  = hi;
    min_q  = lo;
    mean_q = (count_q == 0) ? 16'sd0 : 16'(sum / count_q);
  endfunction

  function automatic void take_sample(input logic signed [15:0] v);
    if (slot_q >= wtsr_pkg::WINDOW) slot_q = 0;
    window_q[slot_q] = v;
    if (count_q < wtsr_pkg::WINDOW) count_q++;
    slot_q   = (slot_q + 1) % wtsr_pkg::WINDOW;
    latest_q = v;
    refresh_stats();
  endfunction

  // Any opcode rewinds the read position; only known ones replace the frame.
  function automatic void build_frame(input logic [7:0] op);
    logic [7:0] code;
    logic [7:0] value;
    rd_pos_q = 0;
    case (op)
      wtsr_pkg::OP_ALL: begin
        frame_q[0]  = wtsr_pkg::START_MARK;
        frame_q[1]  = wtsr_pkg::RSP_ALL;
        frame_q[2]  = 8'(wtsr_pkg::LEN_ALL);
        frame_q[3]  = degrees_byte(latest_q);
        frame_q[4]  = degrees_byte(max_q);
        frame_q[5]  = degrees_byte(min_q);
        frame_q[6]  = degrees_byte(mean_q);
        frame_q[7]  = wtsr_pkg::END_MARK;
        frame_len_q = int'(wtsr_pkg::LEN_ALL);
      end
      wtsr_pkg::OP_LATEST, wtsr_pkg::OP_MAX,
      wtsr_pkg::OP_MIN, wtsr_pkg::OP_MEAN: begin
        case (op)
          wtsr_pkg::OP_LATEST: begin
            code  = wtsr_pkg::RSP_LATEST;
            value = degrees_byte(latest_q);
          end
          wtsr_pkg::OP_MAX: begin
            code  = wtsr_pkg::RSP_MAX;
            value = degrees_byte(max_q);
          end
          wtsr_pkg::OP_MIN: begin
            code  = wtsr_pkg::RSP_MIN;
            value = degrees_byte(min_q);
          end
          default: begin
            code  = wtsr_pkg::RSP_MEAN;
            value = degrees_byte(mean_q);
          end
        endcase
        frame_q[0]  = wtsr_pkg::START_MARK;
        frame_q[1]  = code;
        frame_q[2]  = 8'(wtsr_pkg::LEN_SINGLE);
        frame_q[3]  = value;
        frame_q[4]  = wtsr_pkg::END_MARK;
        frame_len_q = int'(wtsr_pkg::LEN_SINGLE);
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_read();
    if (frame_len_q == 0) begin
      expected_reads.push_back('{data: 8'd0, pos: 3'd0});
    end else begin
      rd_pos_q &= 7;
      expected_reads.push_back('{data: frame_q[rd_pos_q], pos: 3'(rd_pos_q)});
      rd_pos_q = (rd_pos_q + 1) % frame_len_q;
    end
  endfunction

  function automatic void note_mismatch(input bit has_want, input frame_read_t want,
                                        input frame_read_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (has_want)
        $display("%0t: read word mismatch: expected byte %0d pos %0d, got byte %0d pos %0d",
                 $time, want.data, want.pos, got.data, got.pos);
      else
        $display("%0t: unexpected read word: byte %0d pos %0d", $time, got.data, got.pos);
    end
  endfunction

  always @(posedge clk) begin : watch
    frame_read_t got;
    frame_read_t want;
    if (rst) begin
      clear_model();
    end else begin
      // A read word cannot leave in the cycle its request is taken, so check first.
      if (rsp.valid && rsp.ready) begin
        got = '{data: rsp.out_byte, pos: rsp.byte_position};
        if (expected_reads.size() == 0) begin
          note_mismatch(1'b0, got, got);
        end else begin
          want = expected_reads.pop_front();
          if (got.data !== want.data || got.pos !== want.pos) note_mismatch(1'b1, want, got);
        end
      end
      if (req.valid && req.ready) begin
        case (req.req_type)
          wtsr_pkg::REQ_SAMPLE: take_sample(req.sample_value);
          wtsr_pkg::REQ_FRAME:
            if (req.first_byte == wtsr_pkg::START_MARK) build_frame(req.op_byte);
          wtsr_pkg::REQ_READ:   predict_read();
          default: ;
        endcase
      end
    end
    pending_reads = expected_reads.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the temperature statistics responder: clock, reset, stimulus and verdict.
module tb;

  localparam logic [1:0] REQ_NONE    = 2'd3;
  localparam int         WORD_TARGET = 950;
  localparam int         PAUSE_EVERY = 200;
  localparam int         TAIL_CYCLES = 200;
  localparam int         QUIET_LIMIT = 3000;

  typedef enum logic [1:0] {RX_EAGER, RX_CHOPPY, RX_SLUGGISH} rx_mode_e;

  logic     clk = 1'b0;
  logic     rst;
  int       mismatches;
  int       pending_reads;
  int       words_sent = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  int       next_pause;
  bit       req_up = 1'b0;
  rx_mode_e rx_mode = RX_EAGER;
  int       rx_mode_left = 0;
  int       stall_left = 0;

  wtsr_req_if req_ch ();
  wtsr_rsp_if rsp_ch ();

  window_temperature_stats_responder DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  wtsr_stats_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .mismatches    (mismatches),
    .pending_reads (pending_reads)
  );

  always #5 clk = ~clk;

  function automatic bit is_known_op(input logic [7:0] op);
    return op == wtsr_pkg::OP_LATEST || op == wtsr_pkg::OP_MAX || op == wtsr_pkg::OP_MIN ||
           op == wtsr_pkg::OP_MEAN || op == wtsr_pkg::OP_ALL;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 4))
      0:       return wtsr_pkg::OP_LATEST;
      1:       return wtsr_pkg::OP_MAX;
      2:       return wtsr_pkg::OP_MIN;
      3:       return wtsr_pkg::OP_MEAN;
      default: return wtsr_pkg::OP_ALL;
    endcase
  endfunction

  // Mostly plausible temperatures, with full-range values and extremes mixed in.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2:       return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'(int'($urandom_range(0, 2640)) - 640);
    endcase
  endfunction

  task automatic lower_valid();
    if (req_up) begin
      req_ch.valid <= 1'b0;
      req_up = 1'b0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [1:0] kind, input logic signed [15:0] sample,
                           input logic [7:0] first, input logic [7:0] op);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        lower_valid();
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.req_type     <= kind;
    req_ch.sample_value <= sample;
    req_ch.first_byte   <= first;
    req_ch.op_byte      <= op;
    req_ch.valid        <= 1'b1;
    req_up = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    if (!(kind == REQ_NONE || (kind == wtsr_pkg::REQ_FRAME && first != wtsr_pkg::START_MARK)))
      words_sent++;
  endtask

  task automatic send_sample(input logic signed [15:0] v);
    send_word(wtsr_pkg::REQ_SAMPLE, v, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_request(input logic [7:0] first, input logic [7:0] op);
    send_word(wtsr_pkg::REQ_FRAME, 16'($urandom), first, op);
  endtask

  task automatic send_reads(input int n);
    repeat (n) send_word(wtsr_pkg::REQ_READ, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    lower_valid();
    while (pending_reads != 0) @(negedge clk);
  endtask

  // The receiver changes its manner at random, among eager, choppy and sluggish.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_e'($urandom_range(0, 2));
      rx_mode_left <= $urandom_range(50, 300);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    if (stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      case (rx_mode)
        RX_EAGER:  rsp_ch.ready <= 1'b1;
        RX_CHOPPY: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(1, 25);
            rsp_ch.ready <= 1'b0;
          end else begin
            rsp_ch.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: watchdog expired, no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("[window_temperature_stats_responder] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int         pick;
    int         n;
    logic [7:0] op;
    logic [7:0] first;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= wtsr_pkg::REQ_SAMPLE;
    req_ch.sample_value <= '0;
    req_ch.first_byte   <= '0;
    req_ch.op_byte      <= '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reads before any frame, ignored words, then a frame built from extreme samples.
    send_reads(1);
    send_word(REQ_NONE, 16'($urandom), 8'($urandom), 8'($urandom));
    send_request(8'h00, wtsr_pkg::OP_ALL);
    send_reads(1);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sd1);
    send_sample(-16'sd17);
    send_request(wtsr_pkg::START_MARK, wtsr_pkg::OP_ALL);
    send_reads(4);
    // An unknown opcode rewinds the read position but keeps the frame.
    send_request(wtsr_pkg::START_MARK, 8'hff);
    send_reads(1);
    send_request(wtsr_pkg::START_MARK, wtsr_pkg::OP_LATEST);
    send_request(wtsr_pkg::START_MARK, wtsr_pkg::OP_MAX);
    send_request(wtsr_pkg::START_MARK, wtsr_pkg::OP_MEAN);
    send_request(wtsr_pkg::START_MARK, wtsr_pkg::OP_MIN);
    send_reads(6);

    next_pause = PAUSE_EVERY;
    while (words_sent < WORD_TARGET) begin
      if (words_sent >= next_pause) begin
        drain();
        next_pause += PAUSE_EVERY;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n = $urandom_range(0, 4);
        repeat (n) send_sample(pick_sample());
        op = pick_op();
        send_request(wtsr_pkg::START_MARK, op);
        send_reads($urandom_range(1, (op == wtsr_pkg::OP_ALL) ? 18 : 12));
      end else if (pick < 82) begin
        send_word(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 91) begin
        do op = 8'($urandom); while (is_known_op(op));
        send_request(wtsr_pkg::START_MARK, op);
        send_reads($urandom_range(0, 3));
      end else begin
        do first = 8'($urandom); while (first == wtsr_pkg::START_MARK);
        send_request(first, $urandom_range(0, 1) ? pick_op() : 8'($urandom));
        send_reads($urandom_range(0, 3));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_reads == 0)
      $display("[window_temperature_stats_responder] OK");
    else
      $display("[window_temperature_stats_responder] ERROR");
    $finish;
  end

endmodule
